@@ src/qap_swap_delta_engine_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the QAP swap-delta engine
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef QAP_SWAP_DELTA_ENGINE_UNIT_DEFINES_SVH
`define QAP_SWAP_DELTA_ENGINE_UNIT_DEFINES_SVH

// prop must hold at every clock edge
`define QSDE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("qsde assertion failed");

// when cond holds, nxt must hold in the following cycle
`define QSDE_ASSERT_NEXT(name, cond, nxt) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error("qsde assertion failed");

`endif

@@ src/qsde_pkg.sv @@
// ----------------------------------------------------------------------------
// qsde_pkg
// Types, constants and helpers shared by the QAP swap-delta engine.
// ----------------------------------------------------------------------------
package qsde_pkg;

  localparam int MAX_SIZE   = 32;   // power of two: cell address is {row, col}
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_SIZE);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int CELLS      = MAX_SIZE * MAX_SIZE;
  localparam int POS_W      = 6;
  localparam int COST_W     = 42;
  localparam int CHG_W      = 48;
  localparam int SUM_W      = VALUE_BITS + 2;

  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COST_W-1:0]     cost_t;
  typedef logic [CHG_W-1:0]      chg_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [2:0] {
    OP_LOAD_FLOW = 3'd0,
    OP_LOAD_DIST = 3'd1,
    OP_LOAD_PERM = 3'd2,
    OP_EVALUATE  = 3'd3,
    OP_SWAP      = 3'd4
  } op_e;

  typedef struct packed {
    logic sum_clr;
    logic sum_add;
    logic sum_neg;
    logic mul_en;
  } mac_ctrl_t;

  function automatic idx_t pos_idx(pos_t p);
    pos_t t;
    t = p - 1'b1;
    return t[IDX_W-1:0];
  endfunction

  function automatic addr_t cell_addr(pos_t r, pos_t c);
    return {pos_idx(r), pos_idx(c)};
  endfunction

endpackage

@@ src/qap_swap_delta_engine_unit.sv @@
// ----------------------------------------------------------------------------
// qap_swap_delta_engine_unit
// Quadratic assignment cost and pair-swap delta table, memory based.
// ----------------------------------------------------------------------------
// channel   | direction | handshake          | payload
// command   | in        | start & !busy      | operation, row/col index, entry value
// result    | out       | result_valid_o     | total cost, best pair, change, improving
// config    | in        | cfg_we_i           | cfg_wdata_i (size in use)
//
// Loads leave busy low. Evaluate and swap walk the pairs through flow,
// distance, assignment and delta memories (each one read, one write port)
// and one shared multiplier. Evaluate sums the cost over all n*n cells and
// a full delta per pair; a swap redoes pairs touching it in full and the
// rest incrementally. Reset clears control, size and total cost only;
// results cannot be stalled. A term sums its slots, multiplies, then adds.
// ----------------------------------------------------------------------------
module qap_swap_delta_engine_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       operation_i,
  input  qsde_pkg::pos_t   row_index_i,
  input  qsde_pkg::pos_t   col_index_i,
  input  logic [15:0]      entry_value_i,
  input  logic             cfg_we_i,
  input  logic [5:0]       cfg_wdata_i,
  output logic             result_valid_o,
  output qsde_pkg::cost_t  total_cost_o,
  output qsde_pkg::pos_t   best_first_o,
  output qsde_pkg::pos_t   best_second_o,
  output qsde_pkg::chg_t   best_change_o,
  output logic             improving_o
);
  import qsde_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE   = 23'h000001,
    S_SA_RD  = 23'h000002,
    S_SA_WT  = 23'h000004,
    S_SB_RD  = 23'h000008,
    S_SB_WT  = 23'h000010,
    S_SW1    = 23'h000020,
    S_SW2    = 23'h000040,
    S_SC_RD  = 23'h000080,
    S_SC_WT  = 23'h000100,
    S_PI_RD  = 23'h000200,
    S_PI_WT  = 23'h000400,
    S_PJ_RD  = 23'h000800,
    S_PJ_WT  = 23'h001000,
    S_TAB_RD = 23'h002000,
    S_TAB_WT = 23'h004000,
    S_TERM   = 23'h008000,
    S_MUL    = 23'h010000,
    S_ADD    = 23'h020000,
    S_KCHK   = 23'h040000,
    S_PK_RD  = 23'h080000,
    S_PK_WT  = 23'h100000,
    S_DONE   = 23'h200000,
    S_REPORT = 23'h400000
  } state_e;

  typedef enum logic [2:0] {
    T_COST = 3'd0,
    T_F0   = 3'd1,
    T_F1   = 3'd2,
    T_FA   = 3'd3,
    T_FB   = 3'd4,
    T_P0   = 3'd5,
    T_P1   = 3'd6
  } term_e;

  typedef enum logic [1:0] {
    M_EVAL = 2'd0,
    M_SWAP = 2'd1,
    M_KEEP = 2'd2
  } mode_e;

  state_e    state_q, state_d;
  mode_e     mode_q, mode_d;
  term_e     term_q, term_d;
  pos_t      size_q, size_d, n;
  pos_t      i_q, i_d, j_q, j_d, k_q, k_d, lo_q, lo_d, hi_q, hi_d;
  pos_t      pi_q, pi_d, pj_q, pj_d, pk_q, pk_d, pr_q, pr_d, ps_q, ps_d;
  logic [2:0] tc_q, tc_d, nslots;
  logic      first_q, first_d;
  cost_t     cost_q, cost_d;
  chg_t      acc_q, acc_d, best_q, best_d;
  pos_t      bi_q, bi_d, bj_q, bj_d;
  logic      accept, touches, swap_ok;
  pos_t      in_lo, in_hi;
  mac_ctrl_t mac_ctrl;
  chg_t      prod;

  // memories
  value_t flow_mem [CELLS];
  value_t dist_mem [CELLS];
  pos_t   perm_mem [MAX_SIZE];
  chg_t   tab_mem  [CELLS];
  value_t flow_rd_q, dist_rd_q;
  pos_t   perm_rd_q;
  chg_t   tab_rd_q;
  pos_t   fr, fc, dr, dc;
  logic   flow_we, dist_we, mat_ok, perm_ld, perm_we, tab_we;
  idx_t   perm_wa, perm_ra;
  pos_t   perm_wd, perm_rpos;
  addr_t  tab_ra;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    if (size_q < 6'd2) begin
      n = 6'd2;
    end else if (size_q > POS_W'(MAX_SIZE)) begin
      n = POS_W'(MAX_SIZE);
    end else begin
      n = size_q;
    end
  end

  assign size_d = cfg_we_i ? cfg_wdata_i : size_q;

  assign mat_ok = (row_index_i >= 6'd1) && (row_index_i <= POS_W'(MAX_SIZE)) &&
                  (col_index_i >= 6'd1) && (col_index_i <= POS_W'(MAX_SIZE));
  assign flow_we = accept && (operation_i == OP_LOAD_FLOW) && mat_ok;
  assign dist_we = accept && (operation_i == OP_LOAD_DIST) && mat_ok;
  assign perm_ld = accept && (operation_i == OP_LOAD_PERM) &&
                   (row_index_i >= 6'd1) && (row_index_i <= POS_W'(MAX_SIZE)) &&
                   (entry_value_i >= 16'd1) && (entry_value_i <= 16'(MAX_SIZE));

  assign in_lo   = (row_index_i < col_index_i) ? row_index_i : col_index_i;
  assign in_hi   = (row_index_i < col_index_i) ? col_index_i : row_index_i;
  assign swap_ok = (in_lo >= 6'd1) && (in_hi <= n) && (in_lo != in_hi);
  assign touches = (i_q == lo_q) || (i_q == hi_q) || (j_q == lo_q) || (j_q == hi_q);

  // assignment port muxing
  always_comb begin
    perm_we = perm_ld;
    perm_wa = pos_idx(row_index_i);
    perm_wd = POS_W'(entry_value_i);
    if (state_q == S_SW1) begin
      perm_we = 1'b1;
      perm_wa = pos_idx(lo_q);
      perm_wd = ps_q;
    end else if (state_q == S_SW2) begin
      perm_we = 1'b1;
      perm_wa = pos_idx(hi_q);
      perm_wd = pr_q;
    end
    case (state_q)
      S_SA_RD: perm_rpos = lo_q;
      S_SB_RD: perm_rpos = hi_q;
      S_PJ_RD: perm_rpos = j_q;
      S_PK_RD: perm_rpos = k_q;
      default: perm_rpos = i_q;
    endcase
    perm_ra = pos_idx(perm_rpos);
  end

  assign tab_we = (state_q == S_DONE) && (mode_q != M_KEEP) && (i_q < j_q);
  assign tab_ra = (state_q == S_SC_RD) ? cell_addr(lo_q, hi_q) : cell_addr(i_q, j_q);

  // term slot addressing: odd slots subtract
  always_comb begin
    fr = i_q; fc = j_q; dr = pi_q; dc = pj_q;
    case (term_q)
      T_COST: begin
        fr = i_q; fc = j_q; dr = pi_q; dc = pj_q;
      end
      T_F0: begin
        if (!tc_q[0]) begin fr = i_q; fc = i_q; dr = pj_q; dc = pj_q; end
        else begin fr = j_q; fc = j_q; dr = pi_q; dc = pi_q; end
      end
      T_F1: begin
        if (!tc_q[0]) begin fr = i_q; fc = j_q; dr = pj_q; dc = pi_q; end
        else begin fr = j_q; fc = i_q; dr = pi_q; dc = pj_q; end
      end
      T_FA: begin
        if (!tc_q[0]) begin fr = k_q; fc = i_q; dr = pk_q; dc = pj_q; end
        else begin fr = k_q; fc = j_q; dr = pk_q; dc = pi_q; end
      end
      T_FB: begin
        if (!tc_q[0]) begin fr = i_q; fc = k_q; dr = pj_q; dc = pk_q; end
        else begin fr = j_q; fc = k_q; dr = pi_q; dc = pk_q; end
      end
      T_P0: begin
        case (tc_q[1:0])
          2'd0:    begin fr = lo_q; fc = i_q; dr = ps_q; dc = pi_q; end
          2'd1:    begin fr = lo_q; fc = j_q; dr = ps_q; dc = pj_q; end
          2'd2:    begin fr = hi_q; fc = j_q; dr = pr_q; dc = pj_q; end
          default: begin fr = hi_q; fc = i_q; dr = pr_q; dc = pi_q; end
        endcase
      end
      T_P1: begin
        case (tc_q[1:0])
          2'd0:    begin fr = i_q; fc = lo_q; dr = pi_q; dc = ps_q; end
          2'd1:    begin fr = j_q; fc = lo_q; dr = pj_q; dc = ps_q; end
          2'd2:    begin fr = j_q; fc = hi_q; dr = pj_q; dc = pr_q; end
          default: begin fr = i_q; fc = hi_q; dr = pi_q; dc = pr_q; end
        endcase
      end
      default: begin
        fr = i_q; fc = j_q; dr = pi_q; dc = pj_q;
      end
    endcase
    case (term_q)
      T_COST:      nslots = 3'd1;
      T_P0, T_P1:  nslots = 3'd4;
      default:     nslots = 3'd2;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (flow_we) begin
      flow_mem[cell_addr(row_index_i, col_index_i)] <= entry_value_i[VALUE_BITS-1:0];
    end
    flow_rd_q <= flow_mem[cell_addr(fr, fc)];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[cell_addr(row_index_i, col_index_i)] <= entry_value_i[VALUE_BITS-1:0];
    end
    dist_rd_q <= dist_mem[cell_addr(dr, dc)];
  end

  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_wa] <= perm_wd;
    end
    perm_rd_q <= perm_mem[perm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[cell_addr(i_q, j_q)] <= acc_q;
    end
    tab_rd_q <= tab_mem[tab_ra];
  end

  always_comb begin
    mac_ctrl.sum_clr = (state_q == S_TERM) && (tc_q == 3'd0);
    mac_ctrl.sum_add = (state_q == S_TERM) && (tc_q != 3'd0);
    mac_ctrl.sum_neg = ~tc_q[0];
    mac_ctrl.mul_en  = (state_q == S_MUL);
  end

  qsde_mac u_mac (
    .clk_i  (clk_i),
    .flow_i (flow_rd_q),
    .dist_i (dist_rd_q),
    .ctrl_i (mac_ctrl),
    .prod_o (prod)
  );

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    term_d  = term_q;
    i_d = i_q; j_d = j_q; k_d = k_q; lo_d = lo_q; hi_d = hi_q;
    pi_d = pi_q; pj_d = pj_q; pk_d = pk_q; pr_d = pr_q; ps_d = ps_q;
    tc_d    = tc_q;
    first_d = first_q;
    cost_d  = cost_q;
    acc_d   = acc_q;
    best_d  = best_q;
    bi_d    = bi_q;
    bj_d    = bj_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (operation_i == OP_EVALUATE)) begin
          mode_d  = M_EVAL;
          i_d     = 6'd1;
          j_d     = 6'd1;
          cost_d  = '0;
          first_d = 1'b1;
          state_d = S_PI_RD;
        end else if (accept && (operation_i == OP_SWAP)) begin
          lo_d    = in_lo;
          hi_d    = in_hi;
          i_d     = 6'd1;
          j_d     = 6'd2;
          first_d = 1'b1;
          if (swap_ok) begin
            mode_d  = M_SWAP;
            state_d = S_SA_RD;
          end else begin
            mode_d  = M_KEEP;
            state_d = S_TAB_RD;
          end
        end
      end
      S_SA_RD: state_d = S_SA_WT;
      S_SA_WT: begin
        pr_d    = perm_rd_q;
        state_d = S_SB_RD;
      end
      S_SB_RD: state_d = S_SB_WT;
      S_SB_WT: begin
        ps_d    = perm_rd_q;
        state_d = S_SW1;
      end
      S_SW1: state_d = S_SW2;
      S_SW2: begin
        // locations now sit swapped
        pr_d    = ps_q;
        ps_d    = pr_q;
        state_d = S_SC_RD;
      end
      S_SC_RD: state_d = S_SC_WT;
      S_SC_WT: begin
        cost_d  = cost_q + tab_rd_q[COST_W-1:0];
        state_d = S_PI_RD;
      end
      S_PI_RD: state_d = S_PI_WT;
      S_PI_WT: begin
        pi_d    = perm_rd_q;
        state_d = S_PJ_RD;
      end
      S_PJ_RD: state_d = S_PJ_WT;
      S_PJ_WT: begin
        pj_d = perm_rd_q;
        tc_d = 3'd0;
        if (mode_q == M_EVAL) begin
          term_d  = T_COST;
          state_d = S_TERM;
        end else if (touches) begin
          acc_d   = '0;
          term_d  = T_F0;
          state_d = S_TERM;
        end else begin
          state_d = S_TAB_RD;
        end
      end
      S_TAB_RD: state_d = S_TAB_WT;
      S_TAB_WT: begin
        acc_d = tab_rd_q;
        tc_d  = 3'd0;
        if (mode_q == M_KEEP) begin
          state_d = S_DONE;
        end else begin
          term_d  = T_P0;
          state_d = S_TERM;
        end
      end
      S_TERM: begin
        tc_d = tc_q + 3'd1;
        if (tc_q == nslots) begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_ADD;
      S_ADD: begin
        tc_d = 3'd0;
        if (term_q == T_COST) begin
          cost_d = cost_q + prod[COST_W-1:0];
          if (i_q < j_q) begin
            acc_d   = '0;
            term_d  = T_F0;
            state_d = S_TERM;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          acc_d = acc_q + prod;
          case (term_q)
            T_F0: begin
              term_d  = T_F1;
              state_d = S_TERM;
            end
            T_F1: begin
              k_d     = 6'd1;
              state_d = S_KCHK;
            end
            T_FA: begin
              term_d  = T_FB;
              state_d = S_TERM;
            end
            T_FB: begin
              k_d     = k_q + 6'd1;
              state_d = S_KCHK;
            end
            T_P0: begin
              term_d  = T_P1;
              state_d = S_TERM;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_KCHK: begin
        if (k_q > n) begin
          state_d = S_DONE;
        end else if ((k_q == i_q) || (k_q == j_q)) begin
          k_d = k_q + 6'd1;
        end else begin
          state_d = S_PK_RD;
        end
      end
      S_PK_RD: state_d = S_PK_WT;
      S_PK_WT: begin
        pk_d    = perm_rd_q;
        term_d  = T_FA;
        tc_d    = 3'd0;
        state_d = S_TERM;
      end
      S_DONE: begin
        // pairs arrive in row-major order, so strict compare keeps the first
        if ((i_q < j_q) && (first_q || ($signed(acc_q) < $signed(best_q)))) begin
          best_d  = acc_q;
          bi_d    = i_q;
          bj_d    = j_q;
          first_d = 1'b0;
        end
        if (mode_q == M_EVAL) begin
          if (j_q >= n) begin
            j_d = 6'd1;
            i_d = i_q + 6'd1;
            state_d = (i_q >= n) ? S_REPORT : S_PI_RD;
          end else begin
            j_d     = j_q + 6'd1;
            state_d = S_PI_RD;
          end
        end else begin
          if (j_q >= n) begin
            i_d = i_q + 6'd1;
            j_d = i_q + 6'd2;
            if ((i_q + 6'd1) >= n) begin
              state_d = S_REPORT;
            end else begin
              state_d = (mode_q == M_KEEP) ? S_TAB_RD : S_PI_RD;
            end
          end else begin
            j_d     = j_q + 6'd1;
            state_d = (mode_q == M_KEEP) ? S_TAB_RD : S_PI_RD;
          end
        end
      end
      S_REPORT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_EVAL;
      size_q  <= POS_W'(MAX_SIZE);
      i_q     <= 6'd1;
      j_q     <= 6'd2;
      k_q     <= 6'd1;
      tc_q    <= 3'd0;
      first_q <= 1'b1;
      cost_q  <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      size_q  <= size_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      tc_q    <= tc_d;
      first_q <= first_d;
      cost_q  <= cost_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    pi_q   <= pi_d;
    pj_q   <= pj_d;
    pk_q   <= pk_d;
    pr_q   <= pr_d;
    ps_q   <= ps_d;
    acc_q  <= acc_d;
    best_q <= best_d;
    bi_q   <= bi_d;
    bj_q   <= bj_d;
  end

  assign result_valid_o = (state_q == S_REPORT);
  assign total_cost_o   = cost_q;
  assign best_first_o   = bi_q;
  assign best_second_o  = bj_q;
  assign best_change_o  = best_q;
  assign improving_o    = best_q[CHG_W-1];

endmodule

@@ src/qsde_mac.sv @@
// ----------------------------------------------------------------------------
// qsde_mac
// Signed sums of flow and distance reads, then one registered product.
// ----------------------------------------------------------------------------
module qsde_mac (
  input  logic                clk_i,
  input  qsde_pkg::value_t    flow_i,
  input  qsde_pkg::value_t    dist_i,
  input  qsde_pkg::mac_ctrl_t ctrl_i,
  output qsde_pkg::chg_t      prod_o
);
  import qsde_pkg::*;

  logic signed [SUM_W-1:0]   fsum_q, fsum_d, dsum_q, dsum_d, fv, dv;
  logic signed [2*SUM_W-1:0] prod_w;
  chg_t                      prod_q;

  assign fv = $signed({2'b00, flow_i});
  assign dv = $signed({2'b00, dist_i});

  always_comb begin
    fsum_d = fsum_q;
    dsum_d = dsum_q;
    if (ctrl_i.sum_clr) begin
      fsum_d = '0;
      dsum_d = '0;
    end else if (ctrl_i.sum_add) begin
      fsum_d = ctrl_i.sum_neg ? fsum_q - fv : fsum_q + fv;
      dsum_d = ctrl_i.sum_neg ? dsum_q - dv : dsum_q + dv;
    end
  end

  assign prod_w = fsum_q * dsum_q;

  always_ff @(posedge clk_i) begin
    fsum_q <= fsum_d;
    dsum_q <= dsum_d;
    if (ctrl_i.mul_en) begin
      prod_q <= CHG_W'(prod_w);
    end
  end

  assign prod_o = prod_q;

endmodule

@@ src/qsde_checker.sv @@
// ----------------------------------------------------------------------------
// qsde_checker
// Port-level assertions for the QAP swap-delta engine, bound to the top.
// ----------------------------------------------------------------------------
`include "qap_swap_delta_engine_unit_defines.svh"

module qsde_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic [2:0]     operation_i,
  input logic           result_valid_o,
  input qsde_pkg::pos_t best_first_o,
  input qsde_pkg::pos_t best_second_o,
  input qsde_pkg::chg_t best_change_o,
  input logic           improving_o
);
  import qsde_pkg::*;

  logic load_beat;
  assign load_beat = start && !busy && ((operation_i == OP_LOAD_FLOW) ||
                     (operation_i == OP_LOAD_DIST) || (operation_i == OP_LOAD_PERM));

  `QSDE_ASSERT_NEXT(a_result_one_cycle, result_valid_o, !result_valid_o)
  `QSDE_ASSERT(a_result_while_busy, result_valid_o |-> busy)
  `QSDE_ASSERT(a_improving_sign, result_valid_o |-> (improving_o == best_change_o[CHG_W-1]))
  `QSDE_ASSERT(a_pair_ordered, result_valid_o |-> (best_first_o < best_second_o))
  `QSDE_ASSERT_NEXT(a_load_single_cycle, load_beat, !busy)

endmodule

bind qap_swap_delta_engine_unit qsde_checker u_qsde_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: QAP swap-delta engine testbench
// Loads flow/distance/assignment, runs evaluate and swap beats under random
// start gaps and checks each result against an in-bench cost/delta model.
// ----------------------------------------------------------------------------
module tb_top;
  import qsde_pkg::*;

  typedef struct {
    logic [2:0]  op;
    pos_t        row;
    pos_t        col;
    logic [15:0] val;
  } cmd_t;

  typedef struct {
    cost_t cost;
    pos_t  first;
    pos_t  second;
    chg_t  chg;
    logic  imp;
  } score_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  operation_i = '0;
  pos_t        row_index_i = '0;
  pos_t        col_index_i = '0;
  logic [15:0] entry_value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;
  logic        result_valid_o;
  cost_t       total_cost_o;
  pos_t        best_first_o;
  pos_t        best_second_o;
  chg_t        best_change_o;
  logic        improving_o;

  qap_swap_delta_engine_unit u_dut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .row_index_i, .col_index_i,
    .entry_value_i, .cfg_we_i, .cfg_wdata_i, .result_valid_o, .total_cost_o,
    .best_first_o, .best_second_o, .best_change_o, .improving_o
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [15:0]       flow_m [1:MAX_SIZE][1:MAX_SIZE];
  logic [15:0]       dist_m [1:MAX_SIZE][1:MAX_SIZE];
  int unsigned       loc_m [0:MAX_SIZE];
  longint unsigned   chg_m [1:MAX_SIZE][1:MAX_SIZE];
  longint unsigned   cost_m;
  int unsigned       size_m;

  cmd_t   cmd_q[$];
  score_t score_q[$];
  int     errors = 0;
  int     n_results = 0;
  int     n_swaps = 0;
  int     n_evals = 0;
  int     gap = 0;
  bit     calm = 0;

  localparam longint unsigned M42 = (64'd1 << COST_W) - 1;
  localparam longint unsigned M48 = (64'd1 << CHG_W) - 1;

  function automatic longint unsigned fl(int unsigned i, int unsigned j);
    return longint'(flow_m[i][j]);
  endfunction

  function automatic longint unsigned ds(int unsigned u, int unsigned v);
    if (u == 0 || v == 0 || u > MAX_SIZE || v > MAX_SIZE) return 0;
    return longint'(dist_m[u][v]);
  endfunction

  function automatic longint unsigned full_change(int unsigned i, int unsigned j);
    int unsigned pi, pj, pk;
    longint unsigned d;
    pi = loc_m[i];
    pj = loc_m[j];
    d = (fl(i, i) - fl(j, j)) * (ds(pj, pj) - ds(pi, pi))
      + (fl(i, j) - fl(j, i)) * (ds(pj, pi) - ds(pi, pj));
    for (int unsigned k = 1; k <= size_m; k++) begin
      pk = loc_m[k];
      if (k != i && k != j)
        d += (fl(k, i) - fl(k, j)) * (ds(pk, pj) - ds(pk, pi))
           + (fl(i, k) - fl(j, k)) * (ds(pj, pk) - ds(pi, pk));
    end
    return d & M48;
  endfunction

  // incremental update of pair (i,j) after r,s were exchanged
  function automatic longint unsigned step_change(int unsigned i, int unsigned j,
                                                  int unsigned r, int unsigned s);
    int unsigned pi, pj, pr, ps;
    longint unsigned d;
    pi = loc_m[i];
    pj = loc_m[j];
    pr = loc_m[r];
    ps = loc_m[s];
    d = chg_m[i][j];
    d += (fl(r, i) - fl(r, j) + fl(s, j) - fl(s, i))
       * (ds(ps, pi) - ds(ps, pj) + ds(pr, pj) - ds(pr, pi));
    d += (fl(i, r) - fl(j, r) + fl(j, s) - fl(i, s))
       * (ds(pi, ps) - ds(pj, ps) + ds(pj, pr) - ds(pi, pr));
    return d & M48;
  endfunction

  function automatic score_t best_pair();
    score_t sc;
    chg_t   b;
    sc.first = 1;
    sc.second = 2;
    b = chg_t'(chg_m[1][2]);
    for (int unsigned i = 1; i < size_m; i++)
      for (int unsigned j = i + 1; j <= size_m; j++)
        if ($signed(chg_t'(chg_m[i][j])) < $signed(b)) begin
          b = chg_t'(chg_m[i][j]);
          sc.first = pos_t'(i);
          sc.second = pos_t'(j);
        end
    sc.cost = cost_t'(cost_m);
    sc.chg = b;
    sc.imp = b[CHG_W-1];
    return sc;
  endfunction

  task automatic apply_cmd(cmd_t c);
    int unsigned r, k, lo, hi, t;
    longint unsigned acc;
    r = c.row;
    k = c.col;
    case (c.op)
      OP_LOAD_FLOW, OP_LOAD_DIST: begin
        if (r >= 1 && r <= MAX_SIZE && k >= 1 && k <= MAX_SIZE) begin
          if (c.op == OP_LOAD_FLOW) flow_m[r][k] = c.val;
          else dist_m[r][k] = c.val;
        end
      end
      OP_LOAD_PERM: begin
        if (r >= 1 && r <= MAX_SIZE && c.val >= 1 && c.val <= MAX_SIZE)
          loc_m[r] = c.val;
      end
      OP_EVALUATE: begin
        acc = 0;
        for (int unsigned i = 1; i <= size_m; i++)
          for (int unsigned j = 1; j <= size_m; j++) begin
            acc += fl(i, j) * ds(loc_m[i], loc_m[j]);
            if (i < j) chg_m[i][j] = full_change(i, j);
          end
        cost_m = acc & M42;
        score_q.push_back(best_pair());
      end
      OP_SWAP: begin
        lo = r < k ? r : k;
        hi = r < k ? k : r;
        if (lo >= 1 && hi <= size_m && lo != hi) begin
          t = loc_m[lo];
          loc_m[lo] = loc_m[hi];
          loc_m[hi] = t;
          cost_m = (cost_m + chg_m[lo][hi]) & M42;
          for (int unsigned i = 1; i < size_m; i++)
            for (int unsigned j = i + 1; j <= size_m; j++)
              if (i != lo && i != hi && j != lo && j != hi)
                chg_m[i][j] = step_change(i, j, lo, hi);
              else
                chg_m[i][j] = full_change(i, j);
        end
        score_q.push_back(best_pair());
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
             n_results, what, got, want);
    errors++;
  endtask

  // accept side: a command beat lands at start & !busy
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      apply_cmd(cmd_q.pop_front());
    end
  end

  always @(posedge clk_i) begin
    score_t e;
    if (rst_ni && result_valid_o) begin
      if (score_q.size() == 0) begin
        $display("MISMATCH unexpected result beat, cost 0x%0h", total_cost_o);
        errors++;
      end else begin
        e = score_q.pop_front();
        if (total_cost_o !== e.cost) report("total_cost", total_cost_o, e.cost);
        if (best_first_o !== e.first) report("best_first", best_first_o, e.first);
        if (best_second_o !== e.second) report("best_second", best_second_o, e.second);
        if (best_change_o !== e.chg) report("best_change", best_change_o, e.chg);
        if (improving_o !== e.imp) report("improving", improving_o, e.imp);
      end
      n_results++;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // driver: queue head is presented while start is high
  always @(negedge clk_i) begin
    logic go;
    go = 1'b0;
    if (rst_ni) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (cmd_q.size() > 0) begin
        go = 1'b1;
        operation_i <= cmd_q[0].op;
        row_index_i <= cmd_q[0].row;
        col_index_i <= cmd_q[0].col;
        entry_value_i <= cmd_q[0].val;
        if ($urandom_range(0, 19) == 0) calm = !calm;
        // next beat's gap is applied once this one has gone
        if (!calm && start && $urandom_range(0, 3) == 0) begin
          go = 1'b0;
          gap <= pick_gap();
        end
      end
    end
    start <= go;
  end

  // stimulus
  int unsigned locs[$];
  int unsigned n_items = 0;

  task automatic put(logic [2:0] op, int unsigned r, int unsigned c, int unsigned v);
    cmd_t x;
    x.op = op;
    x.row = pos_t'(r);
    x.col = pos_t'(c);
    x.val = v[15:0];
    cmd_q.push_back(x);
    n_items++;
  endtask

  function automatic int unsigned rand_val();
    case ($urandom_range(0, 3))
      0: return 16'hFFFF;
      1: return $urandom_range(0, 15);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic drain();
    while (cmd_q.size() > 0 || start || score_q.size() > 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_size(int unsigned v);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[5:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    size_m = v < 2 ? 2 : (v > MAX_SIZE ? MAX_SIZE : v);
  endtask

  // full problem at the current size: locations drawn from 1..MAX_SIZE
  task automatic load_problem();
    int unsigned n;
    n = size_m;
    locs.delete();
    for (int unsigned i = 1; i <= MAX_SIZE; i++) locs.push_back(i);
    locs.shuffle();
    for (int unsigned i = 1; i <= n; i++)
      for (int unsigned j = 1; j <= n; j++) begin
        put(OP_LOAD_FLOW, i, j, rand_val());
        put(OP_LOAD_DIST, locs[i-1], locs[j-1], rand_val());
      end
    for (int unsigned i = 1; i <= n; i++) put(OP_LOAD_PERM, i, 0, locs[i-1]);
    put(OP_EVALUATE, 0, 0, $urandom_range(0, 65535));
  endtask

  task automatic random_mix(int count);
    int unsigned n, r;
    n = size_m;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        put(OP_SWAP, $urandom_range(1, n), $urandom_range(1, n), $urandom_range(0, 65535));
        n_swaps++;
      end else if (r < 55) begin
        put(OP_SWAP, $urandom_range(0, 63), $urandom_range(0, 63), 0);
      end else if (r < 63) begin
        put(OP_EVALUATE, $urandom_range(0, 63), $urandom_range(0, 63), rand_val());
      end else if (r < 75) begin
        put(OP_LOAD_FLOW, $urandom_range(1, n), $urandom_range(1, n), rand_val());
      end else if (r < 85) begin
        put(OP_LOAD_DIST, locs[$urandom_range(0, n-1)], locs[$urandom_range(0, n-1)],
            rand_val());
      end else if (r < 90) begin
        put(OP_LOAD_PERM, $urandom_range(1, n), 0, locs[$urandom_range(0, n-1)]);
      end else if (r < 93) begin
        // ignored loads: an index out of range
        put($urandom_range(0, 1), $urandom_range(33, 63), $urandom_range(0, 63), rand_val());
      end else if (r < 95) begin
        put($urandom_range(0, 1), $urandom_range(1, 32), 0, rand_val());
      end else if (r < 97) begin
        put(OP_LOAD_PERM, $urandom_range(0, 63), 0,
            $urandom_range(0, 1) ? 0 : $urandom_range(33, 65535));
      end else begin
        put($urandom_range(5, 7), $urandom_range(0, 63), $urandom_range(0, 63), rand_val());
      end
    end
  endtask

  initial begin
    int unsigned sizes[$];
    sizes = '{4, 1, 6};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: size register 0 acts as the minimum size
    set_size(0);
    load_problem();
    put(OP_LOAD_FLOW, 1, 1, 16'hFFFF);
    put(OP_LOAD_DIST, locs[1], locs[1], 16'hFFFF);
    put(OP_EVALUATE, 0, 0, 0);
    put(OP_SWAP, 1, 2, 0);
    put(OP_SWAP, 2, 1, 16'hFFFF);
    put(OP_SWAP, 1, 1, 0);
    put(OP_SWAP, 0, 2, 0);
    put(OP_SWAP, 3, 1, 0);
    put(OP_SWAP, 63, 63, 0);
    put(5, 63, 63, 16'hFFFF);
    put(6, 0, 0, 0);
    put(7, 1, 2, 16'h8000);
    put(OP_LOAD_FLOW, 0, 1, 16'h1234);
    put(OP_LOAD_DIST, 1, 33, 16'h4321);
    put(OP_LOAD_PERM, 1, 0, 0);
    put(OP_LOAD_PERM, 2, 0, 33);
    put(OP_LOAD_PERM, 1, 0, 16'hFFFF);
    put(OP_EVALUATE, 63, 63, 16'hFFFF);

    // random phases; the drain at each size change is the full-pause point
    foreach (sizes[k]) begin
      set_size(sizes[k]);
      load_problem();
      random_mix(45);
    end

    drain();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d command beats over %0d sizes, %0d in-range swaps, %0d results.",
             n_items, sizes.size() + 1, n_swaps, n_results);
    if (errors == 0 && score_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/qsde_pkg.sv
src/qsde_mac.sv
src/qap_swap_delta_engine_unit.sv
src/qsde_checker.sv
tb/tb_top.sv
